// ===== hw/rtl/scp_pkg.sv =====
`default_nettype none

package scp_pkg;

  // internal fixed point value, Q2.30 with headroom
  localparam int unsigned FIX_W = 34;
  localparam int unsigned FRAC_W = 30;
  typedef logic signed [FIX_W-1:0] sq_t;

  // turn scale factors, unsigned Q0.40
  localparam int unsigned TURN_W = 38;
  localparam int unsigned TURN_SPLIT = 19;
  localparam logic [TURN_W-1:0] TURN_RAD = 38'd174992710548;
  localparam logic [TURN_W-1:0] TURN_DEG = 38'd3054198966;

  // angle unit codes
  localparam logic UNIT_RAD = 1'b0;
  localparam logic UNIT_DEG = 1'b1;

  localparam sq_t SIN_C0 = -34'sd4947346;
  localparam sq_t SIN_C1 = 34'sd85557870;
  localparam sq_t SIN_C2 = -34'sd693598150;
  localparam sq_t SIN_C3 = 34'sd1686629710;
  localparam sq_t COS_C0 = -34'sd21946384;
  localparam sq_t COS_C1 = 34'sd272310179;
  localparam sq_t COS_C2 = -34'sd1324672918;
  localparam sq_t COS_C3 = 34'sd1073741824;

  localparam sq_t FIX_ONE = 34'sd1073741824;
  localparam sq_t FIX_TWO = 34'sd2147483648;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] angle;
  } scp_in_t;

  typedef struct packed {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } scp_out_t;

  // sine and cosine pair between pipeline sections
  typedef struct packed {
    sq_t s;
    sq_t c;
  } scp_cs_t;

  // fixed point product, rounded half up
  function automatic sq_t mulq(input sq_t a, input sq_t b);
    logic signed [2*FIX_W-1:0] p;
    p = a * b;
    p = p + ((2*FIX_W)'(1) <<< (FRAC_W - 1));
    return p[FRAC_W+FIX_W-1:FRAC_W];
  endfunction

  function automatic logic signed [31:0] sat_unit(input sq_t v);
    sq_t r;
    if (v > FIX_ONE) begin
      r = FIX_ONE;
    end else if (v < -FIX_ONE) begin
      r = -FIX_ONE;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scp_reduce.sv =====
`default_nettype none

module scp_reduce (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire scp_pkg::scp_in_t up_data,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output scp_pkg::sq_t        dn_q
);

  localparam int unsigned NSTG = 2;
  localparam int unsigned PW = 52;
  localparam int unsigned SW = 56;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  logic [scp_pkg::TURN_W-1:0] k;
  logic signed [PW-1:0] p_lo_nxt, p_lo_r;
  logic signed [PW-1:0] p_hi_nxt, p_hi_r;
  logic [SW-1:0] sum;
  scp_pkg::sq_t q_nxt, q_r;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || dn_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign up_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // angle times turn factor, factor split in two halves
  always_comb begin
    k = (up_data.operation == scp_pkg::UNIT_DEG) ? scp_pkg::TURN_DEG : scp_pkg::TURN_RAD;
    p_lo_nxt = up_data.angle * $signed({1'b0, k[scp_pkg::TURN_SPLIT-1:0]});
    p_hi_nxt = up_data.angle * $signed({1'b0, k[scp_pkg::TURN_W-1:scp_pkg::TURN_SPLIT]});
  end

  // keep 30 bits of the turn fraction, rounded, as a signed fraction
  always_comb begin
    sum = {p_hi_r[SW-scp_pkg::TURN_SPLIT-1:0], {scp_pkg::TURN_SPLIT{1'b0}}}
        + SW'(p_lo_r) + (SW'(1) << 25);
    q_nxt = {{(scp_pkg::FIX_W-30){sum[55]}}, sum[55:26]};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
    end
    if (adv[1]) begin
      q_r <= q_nxt;
    end
  end

  assign dn_valid = vld_r[NSTG-1];
  assign dn_q = q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scp_poly.sv =====
`default_nettype none

module scp_poly (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire scp_pkg::sq_t up_q,
  output logic              dn_valid,
  input  wire logic         dn_ready,
  output scp_pkg::scp_cs_t  dn_data
);

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  scp_pkg::sq_t p0_q_r, p0_q2_r;
  scp_pkg::sq_t p1_q_r, p1_q2_r, p1_s_r, p1_c_r;
  scp_pkg::sq_t p2_q_r, p2_q2_r, p2_s_r, p2_c_r;
  scp_pkg::sq_t p3_q_r, p3_s_r, p3_c_r;
  scp_pkg::sq_t p4_s_r, p4_c_r;
  scp_pkg::sq_t p0_q2_nxt;
  scp_pkg::sq_t p1_s_nxt, p1_c_nxt, p2_s_nxt, p2_c_nxt, p3_s_nxt, p3_c_nxt;
  scp_pkg::sq_t p4_s_nxt;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || dn_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign up_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // quarter angle square, then one horner step per stage
  always_comb begin
    p0_q2_nxt = scp_pkg::mulq(up_q, up_q);
    p1_s_nxt  = scp_pkg::mulq(scp_pkg::SIN_C0, p0_q2_r) + scp_pkg::SIN_C1;
    p1_c_nxt  = scp_pkg::mulq(scp_pkg::COS_C0, p0_q2_r) + scp_pkg::COS_C1;
    p2_s_nxt  = scp_pkg::mulq(p1_s_r, p1_q2_r) + scp_pkg::SIN_C2;
    p2_c_nxt  = scp_pkg::mulq(p1_c_r, p1_q2_r) + scp_pkg::COS_C2;
    p3_s_nxt  = scp_pkg::mulq(p2_s_r, p2_q2_r) + scp_pkg::SIN_C3;
    p3_c_nxt  = scp_pkg::mulq(p2_c_r, p2_q2_r) + scp_pkg::COS_C3;
    p4_s_nxt  = scp_pkg::mulq(p3_s_r, p3_q_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_q_r  <= up_q;
      p0_q2_r <= p0_q2_nxt;
    end
    if (adv[1]) begin
      p1_q_r  <= p0_q_r;
      p1_q2_r <= p0_q2_r;
      p1_s_r  <= p1_s_nxt;
      p1_c_r  <= p1_c_nxt;
    end
    if (adv[2]) begin
      p2_q_r  <= p1_q_r;
      p2_q2_r <= p1_q2_r;
      p2_s_r  <= p2_s_nxt;
      p2_c_r  <= p2_c_nxt;
    end
    if (adv[3]) begin
      p3_q_r <= p2_q_r;
      p3_s_r <= p3_s_nxt;
      p3_c_r <= p3_c_nxt;
    end
    if (adv[4]) begin
      p4_s_r <= p4_s_nxt;
      p4_c_r <= p3_c_r;
    end
  end

  assign dn_valid  = vld_r[NSTG-1];
  assign dn_data.s = p4_s_r;
  assign dn_data.c = p4_c_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scp_double.sv =====
`default_nettype none

module scp_double (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire scp_pkg::scp_cs_t up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output scp_pkg::scp_out_t     dn_data
);

  localparam int unsigned NSTG = 3;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  scp_pkg::sq_t pcc, pss, psc;
  scp_pkg::sq_t m1, m2, m3;
  scp_pkg::sq_t d0_c_nxt, d0_s_nxt, d0_c_r, d0_s_r;
  scp_pkg::sq_t d1_c_nxt, d1_s_nxt, d1_f_nxt, d1_c_r, d1_s_r, d1_f_r;
  scp_pkg::scp_out_t d2_nxt, d2_r;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || dn_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign up_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_comb begin
    // first doubling
    pcc = scp_pkg::mulq(up_data.c, up_data.c);
    pss = scp_pkg::mulq(up_data.s, up_data.s);
    psc = scp_pkg::mulq(up_data.s, up_data.c);
    d0_c_nxt = pcc - pss;
    d0_s_nxt = psc + psc;
    // second doubling and magnitude correction share the squares
    m1 = scp_pkg::mulq(d0_c_r, d0_c_r);
    m2 = scp_pkg::mulq(d0_s_r, d0_s_r);
    m3 = scp_pkg::mulq(d0_s_r + d0_s_r, d0_c_r);
    d1_f_nxt = scp_pkg::FIX_TWO - m1 - m2;
    d1_c_nxt = m1 - m2;
    d1_s_nxt = m3;
    d2_nxt.sine   = scp_pkg::sat_unit(scp_pkg::mulq(d1_s_r, d1_f_r));
    d2_nxt.cosine = scp_pkg::sat_unit(scp_pkg::mulq(d1_c_r, d1_f_r));
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d0_c_r <= d0_c_nxt;
      d0_s_r <= d0_s_nxt;
    end
    if (adv[1]) begin
      d1_c_r <= d1_c_nxt;
      d1_s_r <= d1_s_nxt;
      d1_f_r <= d1_f_nxt;
    end
    if (adv[2]) begin
      d2_r <= d2_nxt;
    end
  end

  assign dn_valid = vld_r[NSTG-1];
  assign dn_data  = d2_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sine_cosine_pair_unit_core.sv =====
// channel | signals                        | payload
// in      | in_valid, in_ready, in_data    | operation, angle (Q16.16)
// out     | out_valid, out_ready, out_data | sine, cosine (Q2.30)
//
// one item per cycle sustained while out_ready stays high; out_valid rises once
// an item has passed all ten register stages: two for turn reduction, five
// for the polynomials, three for doubling, correction and saturation
// synchronous active low reset empties every stage
// each stage holds its item only while the stage after it is full and held,
// so bubbles close up and items are taken while a result waits at the output
`default_nettype none

module sine_cosine_pair_unit_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire scp_pkg::scp_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output scp_pkg::scp_out_t      out_data
);

  logic             rd_valid, pl_ready;
  scp_pkg::sq_t     rd_q;
  logic             pl_valid, db_ready;
  scp_pkg::scp_cs_t pl_data;

  scp_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (rd_valid),
    .dn_ready (pl_ready),
    .dn_q     (rd_q)
  );

  scp_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (rd_valid),
    .up_ready (pl_ready),
    .up_q     (rd_q),
    .dn_valid (pl_valid),
    .dn_ready (db_ready),
    .dn_data  (pl_data)
  );

  scp_double u_double (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pl_valid),
    .up_ready (db_ready),
    .up_data  (pl_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_sine_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sine <= 32'sd1073741824 && out_data.sine >= -32'sd1073741824))
    else $error("sine beyond unit range");

  a_cosine_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cosine <= 32'sd1073741824
                   && out_data.cosine >= -32'sd1073741824))
    else $error("cosine beyond unit range");

  // input stalls only when the whole pipe is full behind a held result
  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && rd_valid && pl_valid))
    else $error("input stalled without a full pipe");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire
